@@ hw/rtl/bbr_pkg.sv @@
// Shared constants, types and the reciprocal table for the 3x3 RGB box blur.
// No dependencies; bbr_ctrl, bbr_datapath, the top level and the testbench import it.
package bbr_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);      // line store address
  localparam int FW_W      = 11;                     // frame_width register
  localparam int FH_W      = 12;                     // frame_height register
  localparam int ROW_W     = FH_W + 1;               // input row, may pass h
  localparam int PIX_W     = 24;
  localparam int SUM_W     = 12;                     // 9 * 255 fits
  localparam int CNT_W     = 4;
  localparam int RCP_SH    = 18;
  localparam int RCP_W     = RCP_SH + 1;
  localparam int PROD_W    = SUM_W + RCP_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
  localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } bbr_reg_e;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic step;
    logic load_out;
  } bbr_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic ignore;
    logic due;
    logic out_free;
  } bbr_stat_t;

  // ceil(2^18 / d): exact floor division for sums below 2304
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RCP_W-1:0] r;
    case (d)
      4'd2:    r = RCP_W'(131072);
      4'd3:    r = RCP_W'(87382);
      4'd4:    r = RCP_W'(65536);
      4'd5:    r = RCP_W'(52429);
      4'd6:    r = RCP_W'(43691);
      4'd7:    r = RCP_W'(37450);
      4'd8:    r = RCP_W'(32768);
      4'd9:    r = RCP_W'(29128);
      default: r = RCP_W'(262144);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/bbr_pix_if.sv @@
// Input pixel channel: valid/ready handshake with RGB payload and flush flag.
// Depends on nothing.
interface bbr_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic       flush;

  modport source (output valid, in_red, in_green, in_blue, flush, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, flush, output ready);
endinterface

@@ hw/rtl/bbr_res_if.sv @@
// Result channel: valid/ready handshake with blurred RGB and frame end flag.
// Depends on nothing.
interface bbr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

@@ hw/rtl/bbr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hw/rtl/bbr_ctrl.sv @@
// Sequencer for the box blur: accept, line store read/update, divide and load.
// Depends on bbr_pkg for the command and status structs.
module bbr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bbr_pkg::bbr_stat_t  stat_i,
  output bbr_pkg::bbr_cmd_t   cmd_o
);
  import bbr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.in_ready = (state_q == S_IDLE);
    cmd_o.capture  = (state_q == S_IDLE) && stat_i.in_valid && !stat_i.ignore;
    cmd_o.step     = (state_q == S_READ);
    cmd_o.load_out = (state_q == S_CALC) && stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (stat_i.in_valid && !stat_i.ignore) state_q <= S_READ;
        end
        S_READ: begin
          state_q <= stat_i.due ? S_CALC : S_IDLE;
        end
        S_CALC: begin
          if (stat_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/bbr_datapath.sv @@
// Datapath: config registers, positions, two line stores, 3x3 window,
// neighbourhood sums, reciprocal divide and output register. Uses bbr_pkg, bbr_ram.
module bbr_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbr_pkg::CFG_DAT_W-1:0] cfg_data_i,
  bbr_pix_if.sink                       pix_i,
  bbr_res_if.source                     res_o,
  input  bbr_pkg::bbr_cmd_t             cmd_i,
  output bbr_pkg::bbr_stat_t            stat_o
);
  import bbr_pkg::*;

  logic [FW_W-1:0]  fw_q, w;
  logic [FH_W-1:0]  fh_q, h;
  logic [COL_W-1:0] icol_q, ocol_q, ic_q, ic_c;
  logic [ROW_W-1:0] irow_q;
  logic [FH_W-1:0]  orow_q;
  logic [PIX_W-1:0] pix_q, pix_c;
  logic             due_q, due_c, done_c;
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] rd_up, rd_mid;
  logic [PIX_W-1:0] nb [3][3];
  logic [2:0]       rm, cm;
  logic [SUM_W-1:0] sum_c [3];
  logic [SUM_W-1:0] sum_q [3];
  logic [CNT_W-1:0] cnt_c, cnt_q;
  logic             fend_c, fend_q;
  logic [PROD_W-1:0] prod [3];
  logic             out_valid_q;
  logic [7:0]       out_q [3];
  logic             out_fend_q;
  logic             restart;

  // effective frame size
  always_comb begin
    if (fw_q == '0)        w = FW_W'(1);
    else if (fw_q > FW_MAX) w = FW_MAX;
    else                   w = fw_q;
    h = (fh_q == '0) ? FH_W'(1) : fh_q;
  end

  always_comb begin
    ic_c   = ({1'b0, icol_q} >= w) ? '0 : icol_q;
    done_c = irow_q >= {1'b0, h};
    due_c  = (irow_q >= ROW_W'(2)) || ((irow_q == ROW_W'(1)) && (ic_c != '0));
    pix_c  = (pix_i.flush || done_c) ? '0 : {pix_i.in_red, pix_i.in_green, pix_i.in_blue};
  end

  assign stat_o.in_valid = pix_i.valid;
  assign stat_o.ignore   = pix_i.flush && !done_c;
  assign stat_o.due      = due_q;
  assign stat_o.out_free = !out_valid_q || res_o.ready;
  assign pix_i.ready     = cmd_i.in_ready;

  bbr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i, .we_i(cmd_i.step), .waddr_i(ic_q), .wdata_i(rd_mid),
    .raddr_i(ic_c), .rdata_o(rd_up)
  );
  bbr_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i, .we_i(cmd_i.step), .waddr_i(ic_q), .wdata_i(pix_q),
    .raddr_i(ic_c), .rdata_o(rd_mid)
  );

  // neighbourhood: left/center from window, right is the incoming column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[r][0] = win_q[r][1];
      nb[r][1] = win_q[r][2];
    end
    nb[0][2] = rd_up;
    nb[1][2] = rd_mid;
    nb[2][2] = pix_q;
    rm[0] = orow_q != '0;
    rm[1] = orow_q < h;
    rm[2] = ({1'b0, orow_q} + 1'b1) < {1'b0, h};
    cm[0] = ocol_q != '0;
    cm[1] = {1'b0, ocol_q} < w;
    cm[2] = (ic_q != '0) && (({1'b0, ocol_q} + 1'b1) < w);
    cnt_c = '0;
    for (int k = 0; k < 3; k++) sum_c[k] = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rm[r] && cm[c]) begin
          cnt_c    = cnt_c + 1'b1;
          sum_c[0] = sum_c[0] + SUM_W'(nb[r][c][23:16]);
          sum_c[1] = sum_c[1] + SUM_W'(nb[r][c][15:8]);
          sum_c[2] = sum_c[2] + SUM_W'(nb[r][c][7:0]);
        end
      end
    end
    if (cnt_c == '0) cnt_c = CNT_W'(1);
    fend_c = (({1'b0, orow_q} + 1'b1) >= {1'b0, h}) && (({1'b0, ocol_q} + 1'b1) >= w);
    for (int k = 0; k < 3; k++) begin
      prod[k] = PROD_W'(sum_q[k]) * PROD_W'(recip(cnt_q));
    end
  end

  assign restart = cmd_i.step && due_q && fend_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= FW_RESET;
      fh_q        <= FH_RESET;
      icol_q      <= '0;
      irow_q      <= '0;
      ocol_q      <= '0;
      orow_q      <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH: begin
            fw_q <= cfg_data_i[FW_W-1:0];
            icol_q <= '0; irow_q <= '0; ocol_q <= '0; orow_q <= '0;
          end
          REG_HEIGHT: begin
            fh_q <= cfg_data_i[FH_W-1:0];
            icol_q <= '0; irow_q <= '0; ocol_q <= '0; orow_q <= '0;
          end
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        if (({1'b0, ic_c} + 1'b1) >= w) begin
          icol_q <= '0;
          if (irow_q != '1) irow_q <= irow_q + 1'b1;
        end else begin
          icol_q <= ic_c + 1'b1;
        end
      end
      if (cmd_i.step) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
          win_q[r][2] <= nb[r][2];
        end
        if (restart) begin
          icol_q <= '0; irow_q <= '0; ocol_q <= '0; orow_q <= '0;
        end else if (due_q) begin
          if (({1'b0, ocol_q} + 1'b1) >= w) begin
            ocol_q <= '0;
            orow_q <= orow_q + 1'b1;
          end else begin
            ocol_q <= ocol_q + 1'b1;
          end
        end
      end
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ic_q  <= ic_c;
      pix_q <= pix_c;
      due_q <= due_c;
    end
    if (cmd_i.step) begin
      sum_q  <= sum_c;
      cnt_q  <= cnt_c;
      fend_q <= fend_c;
    end
    if (cmd_i.load_out) begin
      for (int k = 0; k < 3; k++) out_q[k] <= prod[k][RCP_SH+7:RCP_SH];
      out_fend_q <= fend_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_red   = out_q[0];
  assign res_o.out_green = out_q[1];
  assign res_o.out_blue  = out_q[2];
  assign res_o.frame_end = out_fend_q;
endmodule

@@ hw/rtl/box_blur_3x3_rgb.sv @@
// Top level of the 3x3 RGB box blur: sequencer plus datapath.
// Uses bbr_pkg, bbr_pix_if, bbr_res_if, bbr_ctrl, bbr_datapath.
//
// Usage: send pixels of a frame in raster order on pix_i. Each result on
// res_o is the truncated per-channel mean of the in-frame 3x3 neighbours.
// Results lag by frame_width+1 requests; after the frame's last pixel send
// flush requests (flush=1) until the result with frame_end=1 appears. A
// single-row frame needs one more flush than its width. Flushes sent while
// pixels of the frame are still due are dropped without a result.
// Steps: accept, line store read and update, and for a request with a
// result also the reciprocal multiply into the output register; a dropped
// flush ends in accept. The registered line store read sets read and update
// apart from accept. A new request is taken only in accept, once the last
// is through. res_o.valid rises when the output register is loaded.
// A stalled receiver holds the result; the next request is still accepted
// and waits for the output register only when its own result is ready.
// Reset clears positions, window and valid; registers go to 640 x 480.
// Line stores are not cleared. A width or height write restarts the frame.
module box_blur_3x3_rgb (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bbr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bbr_pkg::CFG_DAT_W-1:0] cfg_data_i,
  bbr_pix_if.sink                       pix_i,
  bbr_res_if.source                     res_o
);
  import bbr_pkg::*;

  bbr_cmd_t  cmd;
  bbr_stat_t stat;

  bbr_ctrl u_ctrl (
    .clk_i, .rst_ni, .stat_i(stat), .cmd_o(cmd)
  );

  bbr_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix_i, .res_o, .cmd_i(cmd), .stat_o(stat)
  );
endmodule

@@ tb/sv/box_blur_3x3_rgb_tb.sv @@
// Self-checking testbench for box_blur_3x3_rgb: directed frames, then random frames.
// Uses bbr_pkg, bbr_pix_if and bbr_res_if; a local blur predictor gives the expected pixels.
module box_blur_3x3_rgb_tb;
  import bbr_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } blur_px_t;

  typedef struct {
    bit       is_cfg;
    bbr_reg_e idx;
    int       data;
    byte      red;
    byte      green;
    byte      blue;
    bit       fl;
    bit       typed;
    blur_px_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;

  bbr_pix_if pix ();
  bbr_res_if res ();

  box_blur_3x3_rgb i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .pix_i     (pix),
    .res_o     (res)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0] upper_px [MAX_WIDTH];
  logic [23:0] middle_px[MAX_WIDTH];
  logic [23:0] win[9];
  int          in_col, in_row, out_col, out_row;
  logic [FW_W-1:0] cur_w = FW_RESET;
  logic [FH_W-1:0] cur_h = FH_RESET;

  blur_px_t blurred_q[$];
  int       errs = 0;
  bit       calm = 1'b0;

  task automatic report(string field, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $time);
    errs++;
  endtask

  function automatic void win_shift(logic [23:0] top, logic [23:0] midv, logic [23:0] bot);
    for (int r = 0; r < 3; r++) begin
      win[r*3+0] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = midv;
    win[8] = bot;
  endfunction

  // mean of in-frame neighbours, centre at window column cc of the middle row
  function automatic void blur_emit(int cc, int w, int h, output blur_px_t px);
    int sr, sg, sb, cnt, rr, oc;
    logic [23:0] p;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      rr = out_row + dr;
      if (rr < 0 || rr >= h) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        oc = out_col + dc;
        if (cc + dc > 2) continue;
        if (oc < 0 || oc >= w) continue;
        p = win[(1+dr)*3+cc+dc];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    px.red   = 8'(sr / cnt);
    px.green = 8'(sg / cnt);
    px.blue  = 8'(sb / cnt);
    px.fend  = (out_row + 1 >= h) && (out_col + 1 >= w);
    if (px.fend) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function automatic void blur_step(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fl,
                                    output bit ign, output bit got, output blur_px_t px);
    int w, h, ic;
    logic [23:0] pv, top, midv;
    bit done, due;
    w = (cur_w == 0) ? 1 : ((cur_w > MAX_WIDTH) ? MAX_WIDTH : int'(cur_w));
    h = (cur_h == 0) ? 1 : int'(cur_h);
    done = in_row >= h;
    ign = fl && !done;
    got = 1'b0;
    px = '0;
    if (ign) return;
    pv = (fl || done) ? 24'h0 : {r, g, b};
    ic = (in_col >= w) ? 0 : in_col;
    top = upper_px[ic];
    midv = middle_px[ic];
    upper_px[ic] = midv;
    middle_px[ic] = pv;
    due = (in_row * w + ic) >= w + 1;
    in_col = ic + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (ic == 0) begin
      if (due) blur_emit(2, w, h, px);
      win_shift(top, midv, pv);
    end else begin
      win_shift(top, midv, pv);
      if (due) blur_emit(1, w, h, px);
    end
    got = due;
  endfunction

  function automatic int gap_len();
    int x;
    x = $urandom_range(0, 99);
    if (calm || x < 50) return 0;
    if (x < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic wait_idle();
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(bbr_reg_e idx, int data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CFG_DAT_W'(data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_WIDTH) cur_w = FW_W'(data);
    else cur_h = FH_W'(data);
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  // one request; returns whether it was ignored and whether it closed the frame
  task automatic send_px(logic [7:0] r, logic [7:0] g, logic [7:0] b, bit fl,
                         bit typed, blur_px_t want, output bit ign, output bit fend);
    bit got;
    blur_px_t px;
    repeat (gap_len()) @(negedge clk_i);
    pix.valid = 1'b1;
    pix.in_red = r;
    pix.in_green = g;
    pix.in_blue = b;
    pix.flush = fl;
    do @(posedge clk_i); while (!pix.ready);
    blur_step(r, g, b, fl, ign, got, px);
    if (got) blurred_q.push_back(typed ? want : px);
    fend = got && px.fend;
    @(negedge clk_i);
    pix.valid = 1'b0;
  endtask

  // receiver side: random stalls, check at each accepted result
  initial begin
    int stall;
    blur_px_t want;
    stall = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res.ready = 1'b0;
        stall--;
      end else begin
        res.ready = 1'b1;
        stall = gap_len();
      end
      @(posedge clk_i);
      if (res.valid && res.ready) begin
        if (blurred_q.size() == 0) begin
          report("unexpected result, red", res.out_red, -1);
        end else begin
          want = blurred_q.pop_front();
          if (res.out_red !== want.red) report("out_red", res.out_red, want.red);
          if (res.out_green !== want.green) report("out_green", res.out_green, want.green);
          if (res.out_blue !== want.blue) report("out_blue", res.out_blue, want.blue);
          if (res.frame_end !== want.fend) report("frame_end", res.frame_end, want.fend);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  dir_row_t dir_tab[] = '{
    '{1, REG_WIDTH,  1, 0, 0, 0, 0, 0, '0},
    '{1, REG_HEIGHT, 1, 0, 0, 0, 0, 0, '0},
    '{0, REG_WIDTH,  0, 8'd255, 8'd0, 8'd128, 0, 0, '0},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 0, '0},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 1, '{8'd255, 8'd0, 8'd128, 1'b1}},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 0, '0},               // early flush, dropped
    '{0, REG_WIDTH,  0, 8'd0, 8'd255, 8'd127, 0, 0, '0},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 0, '0},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 1, '{8'd0, 8'd255, 8'd127, 1'b1}},
    '{1, REG_WIDTH,  0, 0, 0, 0, 0, 0, '0},               // zero size acts as 1
    '{1, REG_HEIGHT, 0, 0, 0, 0, 0, 0, '0},
    '{0, REG_WIDTH,  0, 8'd1, 8'd254, 8'd255, 0, 0, '0},
    '{0, REG_WIDTH,  0, 8'd9, 8'd9, 8'd9, 0, 0, '0},     // pixel past frame: flush
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 1, '{8'd1, 8'd254, 8'd255, 1'b1}},
    '{1, REG_WIDTH,  2, 0, 0, 0, 0, 0, '0},
    '{1, REG_HEIGHT, 2, 0, 0, 0, 0, 0, '0},
    '{0, REG_WIDTH,  0, 8'd255, 8'd255, 8'd255, 0, 0, '0},
    '{0, REG_WIDTH,  0, 8'd0, 8'd0, 8'd0, 0, 0, '0},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 0, '0},
    '{0, REG_WIDTH,  0, 8'd255, 8'd0, 8'd255, 0, 0, '0},
    '{0, REG_WIDTH,  0, 8'd3, 8'd200, 8'd17, 0, 0, '0},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 0, '0},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 0, '0},
    '{0, REG_WIDTH,  0, 0, 0, 0, 1, 0, '0}
  };

  initial begin
    bit ign, fend;
    int w, h, n, sel, rand_items, phase, cut;
    pix.valid = 1'b0;
    pix.in_red = '0;
    pix.in_green = '0;
    pix.in_blue = '0;
    pix.flush = 1'b0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_px[i] = '0;
      middle_px[i] = '0;
    end
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].data);
      else send_px(dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue, dir_tab[i].fl,
                   dir_tab[i].typed, dir_tab[i].want, ign, fend);
    end

    rand_items = 0;
    phase = 0;
    while (rand_items < 950) begin
      sel = $urandom_range(0, 99);
      if (phase == 0) begin
        w = 64; h = 3;                        // widest rows of the run
      end else if (phase == 1) begin
        w = 1; h = 60;
      end else if (sel < 4) begin
        w = 0; h = $urandom_range(0, 4);
      end else if (sel < 8) begin
        w = $urandom_range(1, 6); h = 0;
      end else if (sel < 75) begin
        w = $urandom_range(1, 8); h = $urandom_range(1, 6);
      end else begin
        w = $urandom_range(9, 40); h = $urandom_range(1, 4);
      end
      calm = ($urandom_range(0, 4) == 0);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      n = (w == 0 ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w)) * (h == 0 ? 1 : h);
      cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == cut) break;                  // abandoned frame, restarted by the next write
        if ($urandom_range(0, 9) == 0)
          send_px($urandom, $urandom, $urandom, 1'b1, 1'b0, '0, ign, fend);
        if (i == n / 2 && (phase == 2 || $urandom_range(0, 19) == 0)) begin
          while (blurred_q.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
        send_px($urandom, $urandom, $urandom, 1'b0, 1'b0, '0, ign, fend);
        rand_items++;
      end
      fend = 1'b0;
      while (cut < 0 && !fend) begin
        // a pixel past the frame's end drains like a flush
        if ($urandom_range(0, 6) == 0)
          send_px($urandom, $urandom, $urandom, 1'b0, 1'b0, '0, ign, fend);
        else
          send_px($urandom, $urandom, $urandom, 1'b1, 1'b0, '0, ign, fend);
        rand_items++;
      end
      phase++;
    end

    calm = 1'b0;
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
